### rtl/rjc_pkg.sv
// Shared types and constants of the river junction classifier.
package rjc_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int CELL_W     = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 15;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } rjc_reg_t;

  localparam logic [CELL_W-1:0] CODE_RIVER    = 8'd1;
  localparam logic [CELL_W-1:0] CODE_BEND_NW  = 8'd2;
  localparam logic [CELL_W-1:0] CODE_BEND_SW  = 8'd3;
  localparam logic [CELL_W-1:0] CODE_BEND_NE  = 8'd4;
  localparam logic [CELL_W-1:0] CODE_BEND_SE  = 8'd5;
  localparam logic [CELL_W-1:0] CODE_FORK_NES = 8'd6;
  localparam logic [CELL_W-1:0] CODE_FORK_NWS = 8'd7;
  localparam logic [CELL_W-1:0] CODE_FORK_WNE = 8'd8;
  localparam logic [CELL_W-1:0] CODE_FORK_WSE = 8'd9;
  localparam logic [CELL_W-1:0] CODE_CROSS    = 8'd10;

  typedef struct packed {
    logic [CELL_W-1:0] centre;
    logic              n;
    logic              s;
    logic              e;
    logic              w;
    logic              row_end;
    logic              frame_end;
  } rjc_nbr_t;

endpackage

### rtl/rjc_if.sv
// Valid/ready channel interfaces for cell requests and class results.
interface rjc_cell_if;
  import rjc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic              drain;
  modport source (output valid, cell_value, drain, input ready);
  modport sink   (input valid, cell_value, drain, output ready);
endinterface

interface rjc_class_if;
  import rjc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] class_value;
  logic              row_end;
  logic              frame_end;
  modport source (output valid, class_value, row_end, frame_end, input ready);
  modport sink   (input valid, class_value, row_end, frame_end, output ready);
endinterface

### rtl/rjc_front.sv
// Front end: configuration registers, raster counters, line stores, neighbor gathering.
module rjc_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  rjc_cell_if.sink                       cells,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rjc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rjc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rjc_pkg::APB_DATA_W-1:0] prdata,
  input  logic                           q_full,
  output logic                           push,
  output rjc_pkg::rjc_nbr_t              push_data
);
  import rjc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam logic [LW-1:0] MAX_W = LW'(MAX_WIDTH);

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [CW-1:0]     w_last;
  logic [FH_W-1:0]   h_eff;
  logic [LW-1:0]     wr_width;
  logic [LW-1:0]     wr_last;
  logic [FH_W-1:0]   wr_height;
  rjc_reg_t          wr_reg;
  rjc_reg_t          rd_reg;

  logic [CW-1:0]     col;
  logic [CW-1:0]     col_next;
  logic [FH_W-1:0]   row;
  logic [FH_W-1:0]   row_next;
  logic              west;
  logic              west_next;
  logic [CELL_W-1:0] centre;
  logic [CELL_W-1:0] centre_next;

  logic              cfg_wr;
  logic              accept;
  logic              cell_phase;
  logic              take_cell;
  logic              take_drain;
  logic              col_last;
  logic              rb;
  logic [CELL_W-1:0] pend_x;
  logic              north_bit;

  logic [CELL_W-1:0] pend_mem [MAX_WIDTH];
  logic              up_mem [MAX_WIDTH];
  logic [CW-1:0]     p_ra;
  logic [CW-1:0]     u_ra;
  logic [CELL_W-1:0] p_rd;
  logic              u_rd;
  logic              p_byp;
  logic [CELL_W-1:0] p_byp_data;
  logic              u_byp;
  logic              u_byp_data;
  logic              up_we;

  assign cfg_wr   = psel & penable & pwrite;
  assign wr_reg   = rjc_reg_t'(paddr[APB_ADDR_W-1]);
  assign rd_reg   = rjc_reg_t'(paddr[APB_ADDR_W-1]);
  assign wr_width = LW'(pwdata[FW_W-1:0]);

  always_comb begin
    if (wr_width == '0) begin
      wr_last = '0;
    end else if (wr_width > MAX_W) begin
      wr_last = MAX_W - LW'(1);
    end else begin
      wr_last = wr_width - LW'(1);
    end
  end

  assign wr_height = (pwdata[FH_W-1:0] == '0) ? FH_W'(1) : pwdata[FH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(1);
      frame_height <= FH_W'(1);
      w_last       <= '0;
      h_eff        <= FH_W'(1);
    end else if (cfg_wr) begin
      case (wr_reg)
        REG_FRAME_WIDTH: begin
          frame_width <= pwdata[FW_W-1:0];
          w_last      <= wr_last[CW-1:0];
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= pwdata[FH_W-1:0];
          h_eff        <= wr_height;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rd_reg)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign cells.ready = ~q_full;
  assign accept      = cells.valid & cells.ready;
  assign cell_phase  = (row != h_eff);
  assign take_cell   = accept & cell_phase & ~cells.drain;
  assign take_drain  = accept & ~cell_phase & cells.drain;
  assign col_last    = (col == w_last);
  assign rb          = (centre == CODE_RIVER);
  assign pend_x      = (w_last == '0) ? cells.cell_value : (p_byp ? p_byp_data : p_rd);
  assign north_bit   = u_byp ? u_byp_data : u_rd;

  always_comb begin
    push_data.centre    = centre;
    push_data.n         = (cell_phase ? (row > FH_W'(1)) : (h_eff > FH_W'(1))) & north_bit;
    push_data.s         = cell_phase & (cells.cell_value == CODE_RIVER);
    push_data.e         = ~col_last & (pend_x == CODE_RIVER);
    push_data.w         = (col != '0) & west;
    push_data.row_end   = col_last;
    push_data.frame_end = ~cell_phase & col_last;
  end

  assign push = take_drain | (take_cell & (row != '0));

  always_comb begin
    col_next    = col;
    row_next    = row;
    west_next   = west;
    centre_next = centre;
    if (cfg_wr) begin
      col_next  = '0;
      row_next  = '0;
      west_next = 1'b0;
    end else if (take_cell | take_drain) begin
      centre_next = pend_x;
      west_next   = rb;
      if (col_last) begin
        col_next  = '0;
        west_next = 1'b0;
        row_next  = take_cell ? row + FH_W'(1) : '0;
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      west <= 1'b0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      west <= west_next;
    end
  end

  always_ff @(posedge clk) begin
    centre <= centre_next;
  end

  assign up_we = take_cell | take_drain;
  assign p_ra  = (col_next == w_last) ? '0 : col_next + CW'(1);
  assign u_ra  = col_next;

  always_ff @(posedge clk) begin
    if (take_cell) begin
      pend_mem[col] <= cells.cell_value;
    end
    p_rd <= pend_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      up_mem[col] <= rb;
    end
    u_rd <= up_mem[u_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_byp <= 1'b0;
      u_byp <= 1'b0;
    end else begin
      p_byp <= take_cell & (p_ra == col);
      u_byp <= up_we & (u_ra == col);
    end
    p_byp_data <= cells.cell_value;
    u_byp_data <= rb;
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= w_last)
    else $error("column beyond row width");
  a_row_range: assert property (@(posedge clk) disable iff (rst) row <= h_eff)
    else $error("row beyond drain phase");
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    push && push_data.frame_end |=> col == '0 && row == '0)
    else $error("counters not cleared after frame end");
  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    take_drain && !col_last |=> col == $past(col) + CW'(1) && row == $past(row))
    else $error("drain request did not advance one column");

endmodule

### rtl/rjc_queue.sv
// Two-entry queue between the front end and the back end.
module rjc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rjc_pkg::rjc_nbr_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output rjc_pkg::rjc_nbr_t head
);
  import rjc_pkg::*;

  rjc_nbr_t   slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_data;
    end
  end

endmodule

### rtl/rjc_back.sv
// Back end: junction classification and the output register.
module rjc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rjc_pkg::rjc_nbr_t q_head,
  output logic              pop,
  rjc_class_if.source       classes
);
  import rjc_pkg::*;

  logic              out_valid;
  logic [CELL_W-1:0] out_class;
  logic              out_row_end;
  logic              out_frame_end;

  function automatic logic [CELL_W-1:0] classify(rjc_nbr_t c);
    logic [CELL_W-1:0] k;
    k = c.centre;
    if (c.centre == CODE_RIVER) begin
      if (c.n && c.w) k = CODE_BEND_NW;
      if (c.w && c.s) k = CODE_BEND_SW;
      if (c.n && c.e) k = CODE_BEND_NE;
      if (c.s && c.e) k = CODE_BEND_SE;
      if (c.n && c.e && c.s) k = CODE_FORK_NES;
      if (c.n && c.w && c.s) k = CODE_FORK_NWS;
      if (c.w && c.n && c.e) k = CODE_FORK_WNE;
      if (c.w && c.s && c.e) k = CODE_FORK_WSE;
      if (c.n && c.s && c.e && c.w) k = CODE_CROSS;
    end
    return k;
  endfunction

  assign pop = q_valid & (~out_valid | classes.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (classes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_class     <= classify(q_head);
      out_row_end   <= q_head.row_end;
      out_frame_end <= q_head.frame_end;
    end
  end

  assign classes.valid       = out_valid;
  assign classes.class_value = out_class;
  assign classes.row_end     = out_row_end;
  assign classes.frame_end   = out_frame_end;

endmodule

### rtl/river_junction_classifier.sv
// River junction classifier top level.
// Usage: program frame_width (byte address 0) and frame_height (byte address 4)
// over the APB port while the block is idle; any write restarts the frame.
// Then send cells in row order on the cells channel, frame_width per row and
// frame_height rows, followed by frame_width requests with drain set.
// Each accepted cell of row r > 0 yields the class of the cell above it on
// the classes channel; each drain request yields one class of the last row.
// row_end marks the last cell of a row, frame_end the last cell of the frame.
// Throughput: one request per cycle while the queue has room; the front
// end takes a new request every cycle since the line stores are read one
// column ahead. A class reaches the classes channel through the queue write
// and the output register, from the request completing its neighborhood.
// Receiver stall: results collect in a two-entry queue and the output
// register; the cells channel drops ready only when the queue is full.
// Reset: width and height return to 1, counters and queue clear. The line
// stores are not cleared; the stream order writes each entry before use.
module river_junction_classifier #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  rjc_cell_if.sink                       cells,
  rjc_class_if.source                    classes,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rjc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rjc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rjc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rjc_pkg::*;

  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  rjc_nbr_t push_data;
  rjc_nbr_t q_head;

  assign pready = 1'b1;

  rjc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cells     (cells),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rjc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  rjc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .classes (classes)
  );

endmodule
